[sv/itrt_pkg.sv]
// Package for the integer to radix text converter.
// Holds the character codes, shared types and digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package itrt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int STEP_BITS      = 8;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    typedef logic [RADIX_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    localparam char_t  CH_ZERO        = 8'h30;
    localparam char_t  CH_LETTER_A    = 8'h41;
    localparam char_t  CH_MINUS       = 8'h2D;
    localparam digit_t DECIMAL_DIGITS = 6'd10;
    localparam digit_t RADIX_MIN      = 6'd2;
    localparam digit_t RADIX_MAX      = 6'd36;

    typedef struct packed {
        logic   en;
        digit_t digit;
    } digit_wr_t;

    typedef struct packed {
        logic go;
        logic neg;
    } emit_ctl_t;

    function automatic digit_t sat_radix(input digit_t r);
        digit_t res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic char_t digit_char(input digit_t d);
        char_t res;
        if (d >= DECIMAL_DIGITS)
        begin
            res = {2'b00, d - DECIMAL_DIGITS} + CH_LETTER_A;
        end
        else
        begin
            res = {2'b00, d} + CH_ZERO;
        end
        return res;
    endfunction

endpackage

[sv/itrt_div_unit.sv]
// Shared iterative divider: value by radix, STEP_BITS quotient bits a cycle.
// Depends on itrt_pkg.
`timescale 1ns / 1ps

module itrt_div_unit #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   dividend,
    input  itrt_pkg::digit_t        divisor,
    output logic                    busy,
    output logic                    done,
    output logic [VALUE_BITS-1:0]   quotient,
    output itrt_pkg::digit_t        remainder
);

    localparam int STEP  = itrt_pkg::STEP_BITS;
    localparam int DIV_W = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
    localparam int NCYC  = DIV_W / STEP;
    localparam int CNT_W = $clog2(NCYC + 1);
    localparam int RADIX_W_P = itrt_pkg::RADIX_W;

    logic [DIV_W-1:0]       q_reg, q_next;
    itrt_pkg::digit_t       r_reg, r_next;
    itrt_pkg::digit_t       d_reg, d_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_W-1:0]       q_w;
    itrt_pkg::digit_t       r_w;
    logic [RADIX_W_P:0]     t_w;

    always_comb
    begin
        q_w = q_reg;
        r_w = r_reg;
        t_w = '0;
        for (int i = 0; i < STEP; i++)
        begin
            t_w = {r_w, q_w[DIV_W-1]};
            q_w = {q_w[DIV_W-2:0], 1'b0};
            if (t_w >= {1'b0, d_reg})
            begin
                r_w    = itrt_pkg::digit_t'(t_w - {1'b0, d_reg});
                q_w[0] = 1'b1;
            end
            else
            begin
                r_w = t_w[RADIX_W_P-1:0];
            end
        end
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            q_next   = q_w;
            r_next   = r_w;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NCYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            q_next    = DIV_W'(dividend);
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg[VALUE_BITS-1:0];
    assign remainder = r_reg;

endmodule

[sv/itrt_emitter.sv]
// Digit store and character emitter with output register.
// Depends on itrt_pkg.
`timescale 1ns / 1ps

module itrt_emitter #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  itrt_pkg::digit_wr_t         wr,
    input  logic [$clog2(VALUE_BITS)-1:0] wr_addr,
    input  itrt_pkg::emit_ctl_t         ctl,
    output logic                        busy,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // text_char[7:0]
    output logic                        m_axis_tlast
);

    localparam int AW = $clog2(VALUE_BITS);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SIGN = 2'd1;
    localparam logic [1:0] E_READ = 2'd2;
    localparam logic [1:0] E_LOAD = 2'd3;

    itrt_pkg::digit_t   mem [VALUE_BITS];
    itrt_pkg::digit_t   rd_reg;
    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               ovalid_reg, ovalid_next;
    itrt_pkg::char_t    ochar_reg, ochar_next;
    logic               olast_reg, olast_next;
    logic               out_free;

    assign out_free = !ovalid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.digit;
        end
        rd_reg <= mem[idx_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        unique case (state_reg)
            E_IDLE:
            begin
                if (ctl.go)
                begin
                    idx_next   = wr_addr;
                    state_next = ctl.neg ? E_SIGN : E_READ;
                end
            end
            E_SIGN:
            begin
                if (out_free)
                begin
                    ochar_next  = itrt_pkg::CH_MINUS;
                    olast_next  = 1'b0;
                    ovalid_next = 1'b1;
                    state_next  = E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_LOAD;
            end
            E_LOAD:
            begin
                if (out_free)
                begin
                    ochar_next  = itrt_pkg::digit_char(rd_reg);
                    olast_next  = (idx_reg == '0);
                    ovalid_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign busy          = (state_reg != E_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

[sv/integer_to_radix_text_top.sv]
// Top level of the integer to radix text converter: request sequencer.
// Depends on itrt_pkg, itrt_div_unit and itrt_emitter.
//
//   port group | dir | fields (low bit up)
//   s_axis     | in  | magnitude, is_negative, radix
//   m_axis     | out | text_char; tlast = last_char
//
// Each digit is one division of the value by the radix on the shared divider.
// Emission reads each digit from the digit store, then loads its character into
// the output register; a leading '-' goes out first when is_negative is set.
// s_axis_tready is high only when the sequencer is idle; the last character may
// still wait in the output register. Reset clears all control state.
`timescale 1ns / 1ps

module integer_to_radix_text_top #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // magnitude, is_negative, radix[5:0], zero fill
    input  logic [((VALUE_BITS + 7 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [7:0]                                  m_axis_tdata,   // text_char
    output logic                                        m_axis_tlast
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [CW-1:0]              ndig_reg, ndig_next;
    logic                       neg_reg, neg_next;
    itrt_pkg::digit_t           radix_reg, radix_next;
    logic [VALUE_BITS-1:0]      in_mag;
    logic                       in_neg;
    itrt_pkg::digit_t           in_radix;
    logic                       div_start, div_busy, div_done;
    logic [VALUE_BITS-1:0]      div_dividend, div_quot;
    itrt_pkg::digit_t           div_divisor, div_rem;
    itrt_pkg::digit_wr_t        wr;
    itrt_pkg::emit_ctl_t        ctl;
    logic                       emit_busy;

    assign in_mag   = s_axis_tdata[VALUE_BITS-1:0];
    assign in_neg   = s_axis_tdata[VALUE_BITS];
    assign in_radix = itrt_pkg::sat_radix(s_axis_tdata[VALUE_BITS+6:VALUE_BITS+1]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign div_divisor   = (state_reg == ST_IDLE) ? in_radix : radix_reg;

    always_comb
    begin
        state_next   = state_reg;
        ndig_next    = ndig_reg;
        neg_next     = neg_reg;
        radix_next   = radix_reg;
        div_start    = 1'b0;
        div_dividend = div_quot;
        wr.en        = 1'b0;
        wr.digit     = div_rem;
        ctl.go       = 1'b0;
        ctl.neg      = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    radix_next   = in_radix;
                    neg_next     = in_neg;
                    ndig_next    = '0;
                    div_dividend = in_mag;
                    div_start    = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr.en     = 1'b1;
                    ndig_next = ndig_reg + 1'b1;
                    if (div_quot == '0)
                    begin
                        ctl.go     = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ndig_reg  <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
    end

    itrt_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .busy       (div_busy),
        .done       (div_done),
        .quotient   (div_quot),
        .remainder  (div_rem)
    );

    itrt_emitter #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .wr_addr        (ndig_reg[AW-1:0]),
        .ctl            (ctl),
        .busy           (emit_busy),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast)
    );

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_axis_tready)
        else $error("request taken while divider busy");

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= CW'(VALUE_BITS))
        else $error("digit count above limit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider result outside divide phase");

    a_accept_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !emit_busy)
        else $error("request taken while emitter busy");

endmodule
